// File: rtl/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types and constants for the IPv4 header check and fragment slot
// tracker: status and fragment class codes, queue entry and result formats.
// ----------------------------------------------------------------------------
package ihc_pkg;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_PARSE_ERR = 2'd2;

    localparam logic [1:0] FC_NONE      = 2'd0;
    localparam logic [1:0] FC_DONT_FRAG = 2'd1;
    localparam logic [1:0] FC_FRAG      = 2'd2;
    localparam logic [1:0] FC_LAST      = 2'd3;

    localparam logic       REQ_HEADER   = 1'b0;
    localparam logic       REQ_RELEASE  = 1'b1;

    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [3:0]  VERSION_V4    = 4'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int SLOT_COUNT  = 4;

    typedef struct packed {
        logic        is_rel;
        logic [1:0]  rel_slot;
        logic [1:0]  status;
        logic [1:0]  fclass;
        logic [15:0] offset;
        logic [15:0] payload;
        logic [15:0] cap_body_len;
        logic        way;
        logic [31:0] low_addr;
        logic [31:0] high_addr;
        logic        track;
        logic        more;
        logic [15:0] ident;
        logic [16:0] end_sum;
    } t_work;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  frag_class;
        logic [15:0] frag_offset_bytes;
        logic [15:0] payload_len;
        logic [15:0] cap_body_len;
        logic        way;
        logic [31:0] low_addr;
        logic [31:0] high_addr;
        logic        to_reassembly;
        logic [1:0]  slot;
        logic        slot_evicted;
        logic [16:0] dgram_end;
    } t_result;

endpackage

// File: rtl/ihc_fifo.sv
// ----------------------------------------------------------------------------
// ihc_fifo
// Small register-based queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ihc_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// File: rtl/ihc_front.sv
// ----------------------------------------------------------------------------
// ihc_front
// Accept requests, check the header, derive lengths, fragment class, offset
// and address order, and hand one work entry per request to the queue.
// ----------------------------------------------------------------------------
module ihc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic          i_reasm_en,
    input  logic          i_req_type,
    input  logic [3:0]    i_version,
    input  logic [3:0]    i_ihl_words,
    input  logic [15:0]   i_total_length,
    input  logic [15:0]   i_cap_len,
    input  logic [15:0]   i_link_len,
    input  logic [15:0]   i_frag_word,
    input  logic [31:0]   i_src_addr,
    input  logic [31:0]   i_dst_addr,
    input  logic [15:0]   i_ident,
    input  logic          i_handler_present,
    input  logic [1:0]    i_release_slot,
    output logic          o_q_push,
    output ihc_pkg::t_work o_q_data,
    input  logic          i_q_full
);

    logic            r_valid;
    ihc_pkg::t_work  r_work;
    ihc_pkg::t_work  n_work;
    logic            w_accept;
    logic [15:0]     w_hlen;
    logic [1:0]      w_status;
    logic [15:0]     w_payload;
    logic [15:0]     w_capp_raw;
    logic [15:0]     w_offset;
    logic            w_more;
    logic            w_is_frag;
    logic            w_way;

    assign o_full   = r_valid && i_q_full;
    assign w_accept = i_push && !o_full;
    assign o_q_push = r_valid;
    assign o_q_data = r_work;

    assign w_hlen     = {10'd0, i_ihl_words, 2'b00};
    assign w_payload  = i_total_length - w_hlen;
    assign w_capp_raw = i_cap_len - w_hlen;
    assign w_offset   = {i_frag_word[12:0], 3'b000};
    assign w_more     = i_frag_word[13];
    assign w_is_frag  = w_more || (i_frag_word[12:0] != 13'd0);
    assign w_way      = i_src_addr > i_dst_addr;

    always_comb begin
        if (i_cap_len < ihc_pkg::MIN_HDR_BYTES) begin
            w_status = ihc_pkg::ST_SHORT;
        end else if (i_total_length > i_link_len) begin
            w_status = ihc_pkg::ST_PARSE_ERR;
        end else if (i_version != ihc_pkg::VERSION_V4) begin
            w_status = ihc_pkg::ST_PARSE_ERR;
        end else if (w_hlen > i_total_length) begin
            w_status = ihc_pkg::ST_PARSE_ERR;
        end else if (w_hlen > i_cap_len) begin
            w_status = ihc_pkg::ST_SHORT;
        end else begin
            w_status = ihc_pkg::ST_OK;
        end
    end

    always_comb begin
        n_work          = '0;
        n_work.rel_slot = i_release_slot;
        if (i_req_type == ihc_pkg::REQ_RELEASE) begin
            n_work.is_rel = 1'b1;
        end else if (w_status != ihc_pkg::ST_OK) begin
            n_work.status = w_status;
        end else begin
            n_work.status       = ihc_pkg::ST_OK;
            n_work.offset       = w_offset;
            n_work.payload      = w_payload;
            n_work.cap_body_len = (w_capp_raw > w_payload) ? w_payload : w_capp_raw;
            n_work.way          = w_way;
            n_work.low_addr     = w_way ? i_dst_addr : i_src_addr;
            n_work.high_addr    = w_way ? i_src_addr : i_dst_addr;
            n_work.more         = w_more;
            n_work.ident        = i_ident;
            n_work.end_sum      = {1'b0, w_offset} + {1'b0, w_payload};
            n_work.track        = w_is_frag && i_handler_present && i_reasm_en;
            if (w_is_frag) begin
                n_work.fclass = ihc_pkg::FC_FRAG;
            end else if (i_frag_word[14]) begin
                n_work.fclass = ihc_pkg::FC_DONT_FRAG;
            end else begin
                n_work.fclass = ihc_pkg::FC_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept || (r_valid && i_q_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_work <= n_work;
        end
    end

endmodule

// File: rtl/ihc_back.sv
// ----------------------------------------------------------------------------
// ihc_back
// Take work entries from the queue, look up and update the fragment slot
// table, and push one result per entry to the result queue.
// ----------------------------------------------------------------------------
module ihc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  ihc_pkg::t_work   i_q_data,
    output logic             o_q_pop,
    output logic             o_res_push,
    output ihc_pkg::t_result o_res_data,
    input  logic             i_res_full
);

    localparam int SW = (ihc_pkg::SLOT_COUNT > 1) ? $clog2(ihc_pkg::SLOT_COUNT) : 1;

    logic [ihc_pkg::SLOT_COUNT-1:0] r_in_use;
    logic [ihc_pkg::SLOT_COUNT-1:0] r_got_last;
    logic [15:0]                    r_ident [ihc_pkg::SLOT_COUNT];
    logic [16:0]                    r_end   [ihc_pkg::SLOT_COUNT];

    logic                           w_take;
    logic [ihc_pkg::SLOT_COUNT-1:0] w_hit;
    logic                           w_found;
    logic [SW-1:0]                  w_found_idx;
    logic                           w_free;
    logic [SW-1:0]                  w_free_idx;
    logic [SW-1:0]                  w_sel;
    logic                           w_evict;
    logic                           w_rel_ok;
    logic [SW-1:0]                  w_rel_idx;

    assign w_take     = !i_q_empty && !i_res_full;
    assign o_q_pop    = w_take;
    assign o_res_push = !i_q_empty;

    always_comb begin
        w_hit       = '0;
        w_found     = 1'b0;
        w_found_idx = '0;
        w_free      = 1'b0;
        w_free_idx  = '0;
        for (int s = 0; s < ihc_pkg::SLOT_COUNT; s++) begin
            w_hit[s] = r_in_use[s] && (r_ident[s] == i_q_data.ident);
        end
        for (int s = ihc_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
            if (w_hit[s]) begin
                w_found     = 1'b1;
                w_found_idx = SW'(s);
            end
        end
        for (int s = 0; s < ihc_pkg::SLOT_COUNT; s++) begin
            if (!r_in_use[s]) begin
                w_free     = 1'b1;
                w_free_idx = SW'(s);
            end
        end
    end

    assign w_evict   = !w_found && !w_free;
    assign w_sel     = w_found ? w_found_idx : (w_free ? w_free_idx : '0);
    assign w_rel_ok  = 32'(i_q_data.rel_slot) < ihc_pkg::SLOT_COUNT;
    assign w_rel_idx = SW'(i_q_data.rel_slot);

    always_comb begin
        o_res_data                   = '0;
        o_res_data.status            = i_q_data.status;
        o_res_data.frag_class        = i_q_data.fclass;
        o_res_data.frag_offset_bytes = i_q_data.offset;
        o_res_data.payload_len       = i_q_data.payload;
        o_res_data.cap_body_len      = i_q_data.cap_body_len;
        o_res_data.way               = i_q_data.way;
        o_res_data.low_addr          = i_q_data.low_addr;
        o_res_data.high_addr         = i_q_data.high_addr;
        if (i_q_data.track) begin
            o_res_data.to_reassembly = 1'b1;
            o_res_data.slot          = 2'(w_sel);
            o_res_data.slot_evicted  = w_evict;
            if (!i_q_data.more) begin
                o_res_data.frag_class = ihc_pkg::FC_LAST;
                o_res_data.dgram_end  = i_q_data.end_sum;
            end else if (w_found && r_got_last[w_found_idx]) begin
                o_res_data.dgram_end = r_end[w_found_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use   <= '0;
            r_got_last <= '0;
        end else if (w_take) begin
            if (i_q_data.is_rel) begin
                if (w_rel_ok) begin
                    r_in_use[w_rel_idx]   <= 1'b0;
                    r_got_last[w_rel_idx] <= 1'b0;
                end
            end else if (i_q_data.track) begin
                r_in_use[w_sel]   <= 1'b1;
                r_got_last[w_sel] <= !i_q_data.more || (w_found && r_got_last[w_sel]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !i_q_data.is_rel && i_q_data.track) begin
            if (!w_found) begin
                r_ident[w_sel] <= i_q_data.ident;
            end
            if (!i_q_data.more) begin
                r_end[w_sel] <= i_q_data.end_sum;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_unique_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_hit) <= 1)
        else $error("two live slots hold the same identification");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && i_q_data.track && w_evict |-> (&r_in_use))
        else $error("slot evicted while a slot was free");

    a_track_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && !i_q_data.is_rel && i_q_data.track |=> r_in_use[$past(w_sel)])
        else $error("tracked fragment left its slot unused");
`endif

endmodule

// File: rtl/ipv4_header_check_fragment_slots.sv
// ----------------------------------------------------------------------------
// ipv4_header_check_fragment_slots
// IPv4 header check with fragment tracking in a small identification table.
// ----------------------------------------------------------------------------
// Requests enter on push/full: a header request or a slot release request.
// Each request gives exactly one result on empty/pop, in request order.
// A request is taken when push is high and full is low; the oldest result
// sits on the o_ result ports while empty is low and leaves when pop is high.
// The front stage checks the header and computes lengths, fragment class and
// address order; a two-entry queue feeds the back stage, which looks up the
// slot table (all slots compared at once) and writes a two-entry result queue.
// A request passes the front register, work queue and result queue in turn;
// one request per cycle is taken unless pop stays low: then the result queue
// fills, then the middle queue, then full rises; nothing is dropped. Reset
// empties both queues, frees every slot and sets reassembly enable. The user must
// write i_cfg_wr_data on i_cfg_wr_en only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ipv4_header_check_fragment_slots (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [3:0]  i_version,
    input  logic [3:0]  i_ihl_words,
    input  logic [15:0] i_total_length,
    input  logic [15:0] i_cap_len,
    input  logic [15:0] i_link_len,
    input  logic [15:0] i_frag_word,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_ident,
    input  logic        i_handler_present,
    input  logic [1:0]  i_release_slot,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [1:0]  o_frag_class,
    output logic [15:0] o_frag_offset_bytes,
    output logic [15:0] o_payload_len,
    output logic [15:0] o_cap_body_len,
    output logic        o_way,
    output logic [31:0] o_low_addr,
    output logic [31:0] o_high_addr,
    output logic        o_to_reassembly,
    output logic [1:0]  o_slot,
    output logic        o_slot_evicted,
    output logic [16:0] o_dgram_end
);

    logic             r_reasm_en;
    logic             w_q_push;
    logic             w_q_full;
    logic             w_q_pop;
    logic             w_q_empty;
    ihc_pkg::t_work   w_q_in;
    ihc_pkg::t_work   w_q_out;
    logic             w_res_push;
    logic             w_res_full;
    ihc_pkg::t_result w_res_in;
    ihc_pkg::t_result w_res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reasm_en <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_reasm_en <= i_cfg_wr_data;
        end
    end

    ihc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_reasm_en       (r_reasm_en),
        .i_req_type       (i_req_type),
        .i_version        (i_version),
        .i_ihl_words      (i_ihl_words),
        .i_total_length   (i_total_length),
        .i_cap_len        (i_cap_len),
        .i_link_len       (i_link_len),
        .i_frag_word      (i_frag_word),
        .i_src_addr       (i_src_addr),
        .i_dst_addr       (i_dst_addr),
        .i_ident          (i_ident),
        .i_handler_present(i_handler_present),
        .i_release_slot   (i_release_slot),
        .o_q_push         (w_q_push),
        .o_q_data         (w_q_in),
        .i_q_full         (w_q_full)
    );

    ihc_fifo #(
        .T    (ihc_pkg::t_work),
        .DEPTH(ihc_pkg::QUEUE_DEPTH)
    ) u_work_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_data (w_q_in),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_data (w_q_out),
        .o_empty(w_q_empty)
    );

    ihc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_data  (w_q_out),
        .o_q_pop   (w_q_pop),
        .o_res_push(w_res_push),
        .o_res_data(w_res_in),
        .i_res_full(w_res_full)
    );

    ihc_fifo #(
        .T    (ihc_pkg::t_result),
        .DEPTH(ihc_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res_in),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (w_res_out),
        .o_empty(empty)
    );

    assign o_status            = w_res_out.status;
    assign o_frag_class        = w_res_out.frag_class;
    assign o_frag_offset_bytes = w_res_out.frag_offset_bytes;
    assign o_payload_len       = w_res_out.payload_len;
    assign o_cap_body_len      = w_res_out.cap_body_len;
    assign o_way               = w_res_out.way;
    assign o_low_addr          = w_res_out.low_addr;
    assign o_high_addr         = w_res_out.high_addr;
    assign o_to_reassembly     = w_res_out.to_reassembly;
    assign o_slot              = w_res_out.slot;
    assign o_slot_evicted      = w_res_out.slot_evicted;
    assign o_dgram_end         = w_res_out.dgram_end;

endmodule
